>>> hw/rtl/gbfs_pkg.sv
// shared constants and types of the grid path search block
package gbfs_pkg;

    // default grid size
    localparam int GRID_WIDTH_DEF  = 16;
    localparam int GRID_HEIGHT_DEF = 16;

    // stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    // input word field positions
    localparam int ROW_LSB   = 0;
    localparam int PASS_LSB  = 4;
    localparam int SX_LSB    = 20;
    localparam int SY_LSB    = 28;
    localparam int TX_LSB    = 36;
    localparam int TY_LSB    = 44;

    // opcodes carried in s_tuser
    localparam logic OP_ROW_WRITE = 1'b0;
    localparam logic OP_QUERY     = 1'b1;

    // move directions, in search order
    typedef enum logic [1:0] {
        MV_SOUTH = 2'd0,
        MV_NORTH = 2'd1,
        MV_WEST  = 2'd2,
        MV_EAST  = 2'd3
    } dir_t;

endpackage

>>> hw/rtl/grid_bfs_first_step_unit.sv
// top level: grid breadth-first search returning the first move of a shortest route
//
//   channel  dir  handshake          content
//   s_*      in   tvalid / tready    tuser opcode, tdata row write or query
//   m_*      out  tvalid / tready    tuser found, tdata first move
//
// a row write, or a query with a coordinate out of range or start equal to target, skips
// the search and returns found = 0; a query clears all 2^(log2 W + log2 H) cell store
// entries (256 at 16x16), seeds the start cell, pops cells, then walks the route back;
// the per-cell cost is set by the cell store read port: one neighbor lookup per cycle
// reset leaves every tile blocked; the seen marks are cleared at the start of each query
// a new word is taken while a result still waits on m_*; a stalled m_* holds the last step
module grid_bfs_first_step_unit #(
    parameter int GRID_WIDTH  = gbfs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gbfs_pkg::GRID_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row_index[3:0], row_passable[19:4], start_x[27:20], start_y[35:28],
    // goal_x[43:36], goal_y[51:44], zero fill
    input  logic [gbfs_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // first_dir[1:0], zero fill
    output logic [gbfs_pkg::M_TDATA_W-1:0] m_tdata,
    // found[0]
    output logic                           m_tuser
);
    import gbfs_pkg::*;

    localparam int X_W        = $clog2(GRID_WIDTH);
    localparam int Y_W        = $clog2(GRID_HEIGHT);
    localparam int K_W        = X_W + Y_W;
    localparam int C_W        = K_W + 3;
    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int Q_AW       = $clog2(CELL_COUNT);
    localparam int QP_W       = Q_AW + 1;
    localparam int SEEN_BIT   = K_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_FETCH,
        ST_NBR,
        ST_DRAIN,
        ST_BACK,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [K_W-1:0]    start_key_reg;
    logic [K_W-1:0]    target_key_reg;
    logic [K_W-1:0]    cur_reg;
    dir_t              dir_reg;
    logic [K_W-1:0]    clr_cnt_reg;
    logic [QP_W-1:0]   head_reg;
    logic [QP_W-1:0]   tail_reg;
    logic              p_valid_reg;
    logic [K_W-1:0]    p_key_reg;
    logic [X_W-1:0]    p_x_reg;
    dir_t              p_dir_reg;
    logic              fwd_valid_reg;
    logic [K_W-1:0]    fwd_key_reg;
    logic              res_found_reg;
    dir_t              res_dir_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    dir_t              out_dir_reg;

    // input word fields
    logic [3:0]  f_row;
    logic [15:0] f_pass;
    logic [7:0]  f_sx;
    logic [7:0]  f_sy;
    logic [7:0]  f_tx;
    logic [7:0]  f_ty;
    logic        in_acc;
    logic        row_ok;
    logic        query_ok;

    // memory ports
    logic                  pm_we;
    logic [Y_W-1:0]        pm_waddr;
    logic [GRID_WIDTH-1:0] pm_wdata;
    logic [Y_W-1:0]        pm_raddr;
    logic [GRID_WIDTH-1:0] pm_rdata;
    logic                  cs_we;
    logic [K_W-1:0]        cs_waddr;
    logic [C_W-1:0]        cs_wdata;
    logic [K_W-1:0]        cs_raddr;
    logic [C_W-1:0]        cs_rdata;
    logic                  q_we;
    logic [Q_AW-1:0]       q_waddr;
    logic [K_W-1:0]        q_wdata;
    logic [K_W-1:0]        q_rdata;

    // neighbor generation and evaluation
    logic [X_W-1:0]  cx;
    logic [Y_W-1:0]  cy;
    logic [X_W:0]    x_inc;
    logic [Y_W:0]    y_inc;
    logic [X_W-1:0]  nx;
    logic [Y_W-1:0]  ny;
    logic            nbr_ok;
    logic [K_W-1:0]  nbr_key;
    logic            push;
    logic [QP_W-1:0] tail_upd;
    logic [K_W-1:0]  fetched;
    logic [K_W-1:0]  back_from;
    logic            out_free;

    assign f_row  = s_tdata[ROW_LSB +: 4];
    assign f_pass = s_tdata[PASS_LSB +: 16];
    assign f_sx   = s_tdata[SX_LSB +: 8];
    assign f_sy   = s_tdata[SY_LSB +: 8];
    assign f_tx   = s_tdata[TX_LSB +: 8];
    assign f_ty   = s_tdata[TY_LSB +: 8];

    // input handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign row_ok   = {4'b0000, f_row} < 8'(GRID_HEIGHT);
    assign query_ok = (f_sx < 8'(GRID_WIDTH)) && (f_sy < 8'(GRID_HEIGHT)) &&
                      (f_tx < 8'(GRID_WIDTH)) && (f_ty < 8'(GRID_HEIGHT)) &&
                      !((f_sx == f_tx) && (f_sy == f_ty));

    // row writes go straight to the bitmap
    assign pm_we    = in_acc && (s_tuser == OP_ROW_WRITE) && row_ok;
    assign pm_waddr = Y_W'(f_row);
    assign pm_wdata = GRID_WIDTH'(f_pass);

    // neighbor of the current cell in direction dir_reg
    assign cx    = cur_reg[X_W-1:0];
    assign cy    = cur_reg[K_W-1:X_W];
    assign x_inc = {1'b0, cx} + 1'b1;
    assign y_inc = {1'b0, cy} + 1'b1;

    always_comb
    begin
        nx     = cx;
        ny     = cy;
        nbr_ok = 1'b0;
        unique case (dir_reg)
            MV_SOUTH:
            begin
                nbr_ok = y_inc < (Y_W+1)'(GRID_HEIGHT);
                ny     = y_inc[Y_W-1:0];
            end
            MV_NORTH:
            begin
                nbr_ok = (cy != '0);
                ny     = cy - 1'b1;
            end
            MV_WEST:
            begin
                nbr_ok = (cx != '0);
                nx     = cx - 1'b1;
            end
            MV_EAST:
            begin
                nbr_ok = x_inc < (X_W+1)'(GRID_WIDTH);
                nx     = x_inc[X_W-1:0];
            end
            default:
            begin
                nbr_ok = 1'b0;
            end
        endcase
    end

    assign nbr_key  = {ny, nx};
    assign pm_raddr = ny;

    // a looked-up neighbor joins the queue if unseen and open, the target always open
    assign push = p_valid_reg && !cs_rdata[SEEN_BIT] &&
                  ((p_key_reg == target_key_reg) || pm_rdata[p_x_reg]);
    assign tail_upd = tail_reg + QP_W'(push);

    // head read may hit the entry written on the same edge
    assign fetched   = fwd_valid_reg ? fwd_key_reg : q_rdata;
    assign back_from = cs_rdata[K_W+1:2];

    // cell store port selection
    always_comb
    begin
        cs_we    = 1'b0;
        cs_waddr = p_key_reg;
        cs_wdata = {1'b1, cur_reg, p_dir_reg};
        priority if (state_reg == ST_CLEAR)
        begin
            cs_we    = 1'b1;
            cs_waddr = clr_cnt_reg;
            cs_wdata = '0;
        end
        else if (state_reg == ST_SEED)
        begin
            cs_we    = 1'b1;
            cs_waddr = start_key_reg;
            cs_wdata = {1'b1, {(K_W+2){1'b0}}};
        end
        else
        begin
            cs_we = push;
        end
    end

    always_comb
    begin
        priority if (state_reg == ST_FETCH)
        begin
            cs_raddr = target_key_reg;
        end
        else if (state_reg == ST_BACK)
        begin
            cs_raddr = back_from;
        end
        else
        begin
            cs_raddr = nbr_key;
        end
    end

    // queue port selection
    assign q_we    = (state_reg == ST_SEED) || push;
    assign q_waddr = (state_reg == ST_SEED) ? '0 : tail_reg[Q_AW-1:0];
    assign q_wdata = (state_reg == ST_SEED) ? start_key_reg : p_key_reg;

    assign out_free = !out_valid_reg || m_tready;

    // sequencer, queue pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_key_reg  <= '0;
            target_key_reg <= '0;
            cur_reg        <= '0;
            dir_reg        <= MV_SOUTH;
            clr_cnt_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            p_valid_reg    <= 1'b0;
            p_key_reg      <= '0;
            p_x_reg        <= '0;
            p_dir_reg      <= MV_SOUTH;
            fwd_valid_reg  <= 1'b0;
            fwd_key_reg    <= '0;
            res_found_reg  <= 1'b0;
            res_dir_reg    <= MV_SOUTH;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_dir_reg    <= MV_SOUTH;
        end
        else
        begin
            // neighbor lookup pipeline stage
            p_valid_reg   <= (state_reg == ST_NBR) && nbr_ok;
            p_key_reg     <= nbr_key;
            p_x_reg       <= nx;
            p_dir_reg     <= dir_reg;

            // head word written on the drain edge is taken from the push
            fwd_valid_reg <= (state_reg == ST_DRAIN) && push && (head_reg == tail_reg);

            // result word valid
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        res_found_reg  <= 1'b0;
                        res_dir_reg    <= MV_SOUTH;
                        start_key_reg  <= {Y_W'(f_sy), X_W'(f_sx)};
                        target_key_reg <= {Y_W'(f_ty), X_W'(f_tx)};
                        clr_cnt_reg    <= '0;
                        if ((s_tuser == OP_QUERY) && query_ok)
                        begin
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= ST_SEED;
                    end
                end
                ST_SEED:
                begin
                    head_reg  <= '0;
                    tail_reg  <= QP_W'(1);
                    state_reg <= ST_POP;
                end
                ST_POP:
                begin
                    head_reg  <= head_reg + 1'b1;
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    if (fetched == target_key_reg)
                    begin
                        state_reg <= ST_BACK;
                    end
                    else
                    begin
                        cur_reg   <= fetched;
                        dir_reg   <= MV_SOUTH;
                        state_reg <= ST_NBR;
                    end
                end
                ST_NBR:
                begin
                    tail_reg <= tail_upd;
                    dir_reg  <= dir_t'(dir_reg + 2'd1);
                    if (dir_reg == MV_EAST)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    tail_reg <= tail_upd;
                    if (head_reg == tail_upd)
                    begin
                        res_found_reg <= 1'b0;
                        res_dir_reg   <= MV_SOUTH;
                        state_reg     <= ST_FINISH;
                    end
                    else
                    begin
                        head_reg      <= head_reg + 1'b1;
                        fwd_key_reg   <= p_key_reg;
                        state_reg     <= ST_FETCH;
                    end
                end
                ST_BACK:
                begin
                    if (back_from == start_key_reg)
                    begin
                        res_found_reg <= 1'b1;
                        res_dir_reg   <= dir_t'(cs_rdata[1:0]);
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_found_reg <= res_found_reg;
                        out_dir_reg   <= res_dir_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, out_dir_reg};

    gbfs_pass_map #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_pass_map (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    gbfs_cell_store #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_cell_store (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .raddr (cs_raddr),
        .rdata (cs_rdata)
    );

    gbfs_queue #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[Q_AW-1:0]),
        .rdata (q_rdata)
    );

    // queue pointers stay ordered and in range
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= QP_W'(CELL_COUNT))
        else $error("queue tail beyond cell count");

    // neighbor lookup never reads the cell being written on the same edge
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NBR && push && nbr_ok) |-> (nbr_key != p_key_reg))
        else $error("cell store read and write hit one entry");

    // every cell on the route back was seen in this query
    a_back_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BACK) |-> cs_rdata[SEEN_BIT])
        else $error("route walk reached an unseen cell");

    // forwarded head word only follows a push on the drain cycle
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> (state_reg == ST_FETCH) && $past(push))
        else $error("forwarded queue word without a push");

endmodule

>>> hw/rtl/gbfs_pass_map.sv
// passability bitmap, one row per entry, blocked after reset
module gbfs_pass_map #(
    parameter int GRID_WIDTH  = gbfs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gbfs_pkg::GRID_HEIGHT_DEF,
    localparam int Y_W = $clog2(GRID_HEIGHT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [Y_W-1:0]        waddr,
    input  logic [GRID_WIDTH-1:0] wdata,
    input  logic [Y_W-1:0]        raddr,
    output logic [GRID_WIDTH-1:0] rdata
);
    import gbfs_pkg::*;

    logic [GRID_HEIGHT-1:0] row_valid_reg;
    logic [GRID_WIDTH-1:0]  row_mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0]  rdata_reg;

    // a row reads as blocked until it is first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (we)
        begin
            row_valid_reg[waddr] <= 1'b1;
        end
    end

    // row storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= row_valid_reg[raddr] ? row_mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/gbfs_cell_store.sv
// per-cell search record: seen mark, parent cell and arriving move
module gbfs_cell_store #(
    parameter int GRID_WIDTH  = gbfs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gbfs_pkg::GRID_HEIGHT_DEF,
    localparam int K_W = $clog2(GRID_WIDTH) + $clog2(GRID_HEIGHT),
    localparam int C_W = K_W + 3
) (
    input  logic           clk,
    input  logic           we,
    input  logic [K_W-1:0] waddr,
    input  logic [C_W-1:0] wdata,
    input  logic [K_W-1:0] raddr,
    output logic [C_W-1:0] rdata
);
    import gbfs_pkg::*;

    localparam int DEPTH = 1 << K_W;

    logic [C_W-1:0] cell_mem [DEPTH];
    logic [C_W-1:0] rdata_reg;

    // one write and one read port, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_mem[waddr] <= wdata;
        end
        rdata_reg <= cell_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/gbfs_queue.sv
// search queue of cell keys in visiting order
module gbfs_queue #(
    parameter int GRID_WIDTH  = gbfs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gbfs_pkg::GRID_HEIGHT_DEF,
    localparam int K_W  = $clog2(GRID_WIDTH) + $clog2(GRID_HEIGHT),
    localparam int Q_AW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [Q_AW-1:0] waddr,
    input  logic [K_W-1:0]  wdata,
    input  logic [Q_AW-1:0] raddr,
    output logic [K_W-1:0]  rdata
);
    import gbfs_pkg::*;

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;

    logic [K_W-1:0] q_mem [DEPTH];
    logic [K_W-1:0] rdata_reg;

    // write at tail, read at head, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            q_mem[waddr] <= wdata;
        end
        rdata_reg <= q_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
